[design/lrvs_pkg.sv]
// Shared constants, widths and beat structs for the Lorentz response scaler.
// No dependencies; every module of the block imports this package.
`default_nettype none

package lrvs_pkg;

   // Fixed-point format of the stream and of the internal scale factors
   localparam int FRAC_BITS       = 16;
   localparam int SCALE_FRAC_BITS = 30;
   localparam int MIN_LIGHT_RAW   = ((1 << FRAC_BITS) + 999) / 1000;
   localparam int TINY_SHIFT      = 19;

   // Widths
   localparam int D_W    = 32;                  // one vector component
   localparam int LS_W   = 31;                  // light speed register
   localparam int C2_W   = 2 * LS_W;            // light speed squared
   localparam int N2_W   = 64;                  // |v|^2 and |r.v|
   localparam int G_W    = SCALE_FRAC_BITS + 1; // 1/gamma and 1/gamma^3
   localparam int PQ_W   = 32;                  // parallel part magnitude
   localparam int PROD_W = D_W + N2_W;          // |v_i| * |r.v|

   // Pipeline depths of the two branches and the delay that aligns them
   localparam int LAT_GAMMA = 2 * SCALE_FRAC_BITS + 4;
   localparam int LAT_PAR   = PQ_W + 2;
   localparam int ALIGN     = LAT_GAMMA - LAT_PAR;

   localparam logic [LS_W-1:0] LS_RESET = 31'd5242880;

   // Per-item fields that ride alongside the arithmetic
   typedef struct packed {
      logic [2:0][D_W-1:0] r;       // response components
      logic [2:0]          psgn;    // sign of the parallel part per lane
      logic                bypass;  // pass the response through
   } side_type;

   // Front end result
   typedef struct packed {
      logic [N2_W-1:0]     n2;
      logic [C2_W-1:0]     c2;
      logic [N2_W-1:0]     dmag;
      logic [2:0][D_W-1:0] vabs;
      side_type            side;
   } prep_type;

   // Parallel part branch result
   typedef struct packed {
      logic [2:0][PQ_W-1:0] pm;
      side_type             side;
   } par_type;

endpackage

`default_nettype wire

[design/lorentz_response_vector_scale_top.sv]
// Top level of the Lorentz response scaler: stream ports, light speed register,
// branch alignment. Instantiates lrvs_prep, lrvs_gamma, lrvs_par_div, lrvs_scale.
`default_nettype none

// Splits each response vector into parts parallel and perpendicular to the
// velocity and scales them by 1/gamma^3 and 1/gamma; all values are signed
// Q15.16, results saturate to 32 bits, and rsp_tuser is 0 when the response
// passed through unscaled. The pipeline takes one beat per clock while
// rsp_tready does not stall it, and has 3 front end stages, 64 for the
// beta^2 divider, square root and cube, and 4 back end stages; the depth comes
// from the one-bit-per-stage divider and root. A stall on rsp_tready freezes
// the whole pipeline and drops req_tready in the same cycle. Write light
// speed only while nothing is in flight.
module lorentz_response_vector_scale_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // resp_x, resp_y, resp_z, vel_x, vel_y, vel_z
   input  logic [6*lrvs_pkg::D_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // out_x, out_y, out_z
   output logic [3*lrvs_pkg::D_W-1:0]  rsp_tdata,
   // applied
   output logic                        rsp_tuser,
   input  logic                        csr_wr_en,
   input  logic [lrvs_pkg::LS_W-1:0]   csr_wr_data
);
   import lrvs_pkg::*;

   logic                en;
   logic [LS_W-1:0]     ls_ff;
   logic [2:0][D_W-1:0] resp, vel;

   logic                pp_valid;
   prep_type            pp_data;
   logic                gm_valid;
   logic [G_W-1:0]      gm_g, gm_g3;
   logic                pd_valid;
   par_type             pd_data;
   logic [ALIGN-1:0]    al_valid_ff;
   par_type             al_data_ff [ALIGN];
   logic                al_valid;
   logic [2:0][D_W-1:0] sc_data;

   // whole pipeline advances unless the result register is held
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // light speed register
   always_ff @(posedge clock) begin
      if (reset) begin
         ls_ff <= LS_RESET;
      end else if (csr_wr_en) begin
         ls_ff <= csr_wr_data;
      end
   end

   // unpack the request beat
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         resp[i] = req_tdata[D_W*i +: D_W];
         vel[i]  = req_tdata[D_W*(i+3) +: D_W];
      end
   end

   lrvs_prep u_prep (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_tvalid),
      .resp        (resp),
      .vel         (vel),
      .light_speed (ls_ff),
      .out_valid   (pp_valid),
      .out_data    (pp_data)
   );

   lrvs_gamma u_gamma (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pp_valid),
      .n2        (pp_data.n2),
      .c2        (pp_data.c2),
      .out_valid (gm_valid),
      .g         (gm_g),
      .g3        (gm_g3)
   );

   lrvs_par_div u_par_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pp_valid),
      .in_data   (pp_data),
      .out_valid (pd_valid),
      .out_data  (pd_data)
   );

   // delay the parallel branch to meet the gamma branch
   always_ff @(posedge clock) begin
      if (reset) begin
         al_valid_ff <= '0;
      end else if (en) begin
         al_valid_ff <= {al_valid_ff[ALIGN-2:0], pd_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         al_data_ff[0] <= pd_data;
         for (int k = 1; k < ALIGN; k++) begin
            al_data_ff[k] <= al_data_ff[k-1];
         end
      end
   end

   assign al_valid = al_valid_ff[ALIGN-1];

   lrvs_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (al_valid),
      .g         (gm_g),
      .g3        (gm_g3),
      .in_data   (al_data_ff[ALIGN-1]),
      .out_valid (rsp_tvalid),
      .out_data  (sc_data),
      .applied   (rsp_tuser)
   );

   assign rsp_tdata = sc_data;

   // both branches carry the same item at the join
   a_branch_align : assert property (@(posedge clock) disable iff (reset)
      gm_valid == al_valid)
      else $error("gamma and parallel branches out of step");

   // 1/gamma never exceeds one
   a_g_range : assert property (@(posedge clock) disable iff (reset)
      gm_valid && gm_g[G_W-1] |-> gm_g[G_W-2:0] == '0)
      else $error("1/gamma above one");

   // 1/gamma^3 never exceeds 1/gamma
   a_g3_order : assert property (@(posedge clock) disable iff (reset)
      gm_valid |-> gm_g3 <= gm_g)
      else $error("1/gamma^3 above 1/gamma");

endmodule

`default_nettype wire

[design/lrvs_prep.sv]
// Front end: squares, dot product, light speed squared and pass-through tests.
// Three register stages; depends on lrvs_pkg.
`default_nettype none

module lrvs_prep (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [2:0][lrvs_pkg::D_W-1:0] resp,
   input  logic [2:0][lrvs_pkg::D_W-1:0] vel,
   input  logic [lrvs_pkg::LS_W-1:0]    light_speed,
   output logic                         out_valid,
   output lrvs_pkg::prep_type           out_data
);
   import lrvs_pkg::*;

   localparam int SQ_W  = 2 * D_W - 1;
   localparam int PR_W  = 2 * D_W;
   localparam int DOT_W = PR_W + 2;

   // stage 1 registers
   logic                  s1_valid_ff;
   logic [2:0][D_W-1:0]   s1_r_ff;
   logic [2:0][SQ_W-1:0]  s1_sq_ff, s1_sq_in;
   logic [2:0][PR_W-1:0]  s1_pr_ff, s1_pr_in;
   logic [2:0][D_W-1:0]   s1_vabs_ff, s1_vabs_in;
   logic [2:0]            s1_vneg_ff;
   logic [C2_W-1:0]       s1_c2_ff, s1_c2_in;
   logic                  s1_lsmall_ff;
   logic                  s1_rzero_ff;

   // stage 2 registers
   logic                  s2_valid_ff;
   logic [2:0][D_W-1:0]   s2_r_ff;
   logic [N2_W-1:0]       s2_n2_ff, s2_n2_in;
   logic [DOT_W-1:0]      s2_dot_ff, s2_dot_in;
   logic [2:0][D_W-1:0]   s2_vabs_ff;
   logic [2:0]            s2_vneg_ff;
   logic [C2_W-1:0]       s2_c2_ff;
   logic                  s2_lsmall_ff;
   logic                  s2_rzero_ff;

   // stage 3 registers
   logic                  s3_valid_ff;
   prep_type              s3_data_ff, s3_data_in;
   logic                  dneg;

   // products of the input components
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_sq_in[i]   = SQ_W'(PR_W'($signed(vel[i])) * PR_W'($signed(vel[i])));
         s1_pr_in[i]   = PR_W'($signed(resp[i])) * PR_W'($signed(vel[i]));
         s1_vabs_in[i] = vel[i][D_W-1] ? D_W'(0) - vel[i] : vel[i];
      end
      s1_c2_in = C2_W'(light_speed) * C2_W'(light_speed);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_r_ff      <= resp;
         s1_sq_ff     <= s1_sq_in;
         s1_pr_ff     <= s1_pr_in;
         s1_vabs_ff   <= s1_vabs_in;
         s1_vneg_ff   <= {vel[2][D_W-1], vel[1][D_W-1], vel[0][D_W-1]};
         s1_c2_ff     <= s1_c2_in;
         s1_lsmall_ff <= light_speed < LS_W'(MIN_LIGHT_RAW);
         s1_rzero_ff  <= (resp[0] == '0) && (resp[1] == '0) && (resp[2] == '0);
      end
   end

   // |v|^2 and r.v
   always_comb begin
      s2_n2_in  = N2_W'(s1_sq_ff[0]) + N2_W'(s1_sq_ff[1]) + N2_W'(s1_sq_ff[2]);
      s2_dot_in = DOT_W'($signed(s1_pr_ff[0])) + DOT_W'($signed(s1_pr_ff[1]))
                + DOT_W'($signed(s1_pr_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_r_ff      <= s1_r_ff;
         s2_n2_ff     <= s2_n2_in;
         s2_dot_ff    <= s2_dot_in;
         s2_vabs_ff   <= s1_vabs_ff;
         s2_vneg_ff   <= s1_vneg_ff;
         s2_c2_ff     <= s1_c2_ff;
         s2_lsmall_ff <= s1_lsmall_ff;
         s2_rzero_ff  <= s1_rzero_ff;
      end
   end

   // dot magnitude, lane signs and the pass-through decision
   assign dneg = s2_dot_ff[DOT_W-1];

   always_comb begin
      s3_data_in.n2          = s2_n2_ff;
      s3_data_in.c2          = s2_c2_ff;
      s3_data_in.dmag        = N2_W'(dneg ? DOT_W'(0) - s2_dot_ff : s2_dot_ff);
      s3_data_in.vabs        = s2_vabs_ff;
      s3_data_in.side.r      = s2_r_ff;
      s3_data_in.side.psgn   = s2_vneg_ff ^ {3{dneg}};
      s3_data_in.side.bypass = s2_lsmall_ff || s2_rzero_ff || (s2_n2_ff == '0)
                            || (s2_n2_ff <= N2_W'(s2_c2_ff >> TINY_SHIFT));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_data_ff <= s3_data_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_data_ff;

endmodule

`default_nettype wire

[design/lrvs_gamma.sv]
// 1/gamma and 1/gamma^3 from |v|^2 and c^2: bit-per-stage divider for beta^2,
// bit-per-stage square root, then two multiply stages. Depends on lrvs_pkg.
`default_nettype none

module lrvs_gamma (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [lrvs_pkg::N2_W-1:0]   n2,
   input  logic [lrvs_pkg::C2_W-1:0]   c2,
   output logic                        out_valid,
   output logic [lrvs_pkg::G_W-1:0]    g,
   output logic [lrvs_pkg::G_W-1:0]    g3
);
   import lrvs_pkg::*;

   localparam int S     = SCALE_FRAC_BITS;
   localparam int X_W   = 2 * S + 2;
   localparam int T_W   = 2 * S + 3;
   localparam int GG_W  = S + 2;
   localparam int GGF_W = 2 * G_W;
   localparam int G3F_W = GG_W + G_W;

   // divider stages
   logic [S-1:0]    dv_valid_ff;
   logic [C2_W-1:0] dv_rem_ff [S];
   logic [C2_W-1:0] dv_rem_in [S];
   logic [C2_W-1:0] dv_rem_src [S];
   logic [S-1:0]    dv_q_ff [S];
   logic [S-1:0]    dv_q_in [S];
   logic [S-1:0]    dv_q_src [S];
   logic [C2_W-1:0] dv_c2_ff [S];
   logic [C2_W-1:0] dv_c2_src [S];
   logic [S-1:0]    dv_ge_ff;
   logic [S-1:0]    dv_ge_src;
   logic [S-1:0]    dv_valid_src;
   logic [C2_W:0]   dv_sh [S];
   logic            ge_head;

   // 1 - beta^2
   logic            om_valid_ff;
   logic [S:0]      om_ff, om_in;

   // root stages
   logic [S:0]      sq_valid_ff;
   logic [S:0]      sq_valid_src;
   logic [X_W-1:0]  sq_rem_ff [S+1];
   logic [X_W-1:0]  sq_rem_in [S+1];
   logic [X_W-1:0]  sq_rem_src [S+1];
   logic [G_W-1:0]  sq_g_ff [S+1];
   logic [G_W-1:0]  sq_g_in [S+1];
   logic [G_W-1:0]  sq_g_src [S+1];
   logic [T_W-1:0]  sq_t [S+1];

   // cube stages
   logic            m1_valid_ff;
   logic [GG_W-1:0] m1_gg_ff;
   logic [G_W-1:0]  m1_g_ff;
   logic [GGF_W-1:0] m1_ggf;
   logic            m2_valid_ff;
   logic [G_W-1:0]  m2_g_ff;
   logic [G_W-1:0]  m2_g3_ff;
   logic [G3F_W-1:0] m2_g3f;

   assign ge_head = n2 >= N2_W'(c2);

   // restoring division n2 * 2^S / c2, one quotient bit a stage
   always_comb begin
      dv_rem_src[0]   = ge_head ? '0 : n2[C2_W-1:0];
      dv_q_src[0]     = '0;
      dv_c2_src[0]    = c2;
      dv_ge_src[0]    = ge_head;
      dv_valid_src[0] = in_valid;
      for (int k = 1; k < S; k++) begin
         dv_rem_src[k]   = dv_rem_ff[k-1];
         dv_q_src[k]     = dv_q_ff[k-1];
         dv_c2_src[k]    = dv_c2_ff[k-1];
         dv_ge_src[k]    = dv_ge_ff[k-1];
         dv_valid_src[k] = dv_valid_ff[k-1];
      end
      for (int k = 0; k < S; k++) begin
         dv_sh[k] = {dv_rem_src[k], 1'b0};
         if (dv_sh[k] >= {1'b0, dv_c2_src[k]}) begin
            dv_rem_in[k] = C2_W'(dv_sh[k] - {1'b0, dv_c2_src[k]});
            dv_q_in[k]   = {dv_q_src[k][S-2:0], 1'b1};
         end else begin
            dv_rem_in[k] = dv_sh[k][C2_W-1:0];
            dv_q_in[k]   = {dv_q_src[k][S-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff <= '0;
      end else if (en) begin
         dv_valid_ff <= dv_valid_src;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < S; k++) begin
            dv_rem_ff[k] <= dv_rem_in[k];
            dv_q_ff[k]   <= dv_q_in[k];
            dv_c2_ff[k]  <= dv_c2_src[k];
         end
         dv_ge_ff <= dv_ge_src;
      end
   end

   // 1 - beta^2, held at one LSB at or above light speed
   assign om_in = dv_ge_ff[S-1] ? (S+1)'(1) : ((S+1)'(1) << S) - (S+1)'(dv_q_ff[S-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         om_valid_ff <= 1'b0;
      end else if (en) begin
         om_valid_ff <= dv_valid_ff[S-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         om_ff <= om_in;
      end
   end

   // digit-by-digit square root of om * 2^S, one root bit a stage
   always_comb begin
      sq_rem_src[0]   = X_W'(om_ff) << S;
      sq_g_src[0]     = '0;
      sq_valid_src[0] = om_valid_ff;
      for (int j = 1; j <= S; j++) begin
         sq_rem_src[j]   = sq_rem_ff[j-1];
         sq_g_src[j]     = sq_g_ff[j-1];
         sq_valid_src[j] = sq_valid_ff[j-1];
      end
      for (int j = 0; j <= S; j++) begin
         sq_t[j] = (T_W'(sq_g_src[j]) << (S - j + 1)) + (T_W'(1) << (2 * (S - j)));
         if (sq_t[j] <= T_W'(sq_rem_src[j])) begin
            sq_rem_in[j] = X_W'(T_W'(sq_rem_src[j]) - sq_t[j]);
            sq_g_in[j]   = sq_g_src[j] | (G_W'(1) << (S - j));
         end else begin
            sq_rem_in[j] = sq_rem_src[j];
            sq_g_in[j]   = sq_g_src[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= '0;
      end else if (en) begin
         sq_valid_ff <= sq_valid_src;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j <= S; j++) begin
            sq_rem_ff[j] <= sq_rem_in[j];
            sq_g_ff[j]   <= sq_g_in[j];
         end
      end
   end

   // g^3 in two multiply stages, truncating after each
   assign m1_ggf = GGF_W'(sq_g_ff[S]) * GGF_W'(sq_g_ff[S]);
   assign m2_g3f = G3F_W'(m1_gg_ff) * G3F_W'(m1_g_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
      end else if (en) begin
         m1_valid_ff <= sq_valid_ff[S];
         m2_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_gg_ff <= GG_W'(m1_ggf >> S);
         m1_g_ff  <= sq_g_ff[S];
         m2_g3_ff <= G_W'(m2_g3f >> S);
         m2_g_ff  <= m1_g_ff;
      end
   end

   assign out_valid = m2_valid_ff;
   assign g         = m2_g_ff;
   assign g3        = m2_g3_ff;

endmodule

`default_nettype wire

[design/lrvs_par_div.sv]
// Parallel part magnitude |v_i|*|r.v|/|v|^2 for three lanes: split multiply
// over two stages, then a one-bit-per-stage divider. Depends on lrvs_pkg.
`default_nettype none

module lrvs_par_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  lrvs_pkg::prep_type           in_data,
   output logic                         out_valid,
   output lrvs_pkg::par_type            out_data
);
   import lrvs_pkg::*;

   localparam int HALF = N2_W / 2;

   // partial products
   logic                   pa_valid_ff;
   logic [2:0][N2_W-1:0]   pa_lo_ff, pa_hi_ff;
   logic [N2_W-1:0]        pa_n2_ff;
   side_type               pa_side_ff;

   // full dividend
   logic                   pb_valid_ff;
   logic [2:0][PROD_W-1:0] pb_prod_ff;
   logic [N2_W-1:0]        pb_n2_ff;
   side_type               pb_side_ff;

   // divider stages
   logic [PQ_W-1:0]           dv_valid_ff;
   logic [PQ_W-1:0]           dv_valid_src;
   logic [2:0][PROD_W-1:0]    dv_rem_ff [PQ_W];
   logic [2:0][PROD_W-1:0]    dv_rem_in [PQ_W];
   logic [2:0][PROD_W-1:0]    dv_rem_src [PQ_W];
   logic [2:0][PQ_W-1:0]      dv_q_ff [PQ_W];
   logic [2:0][PQ_W-1:0]      dv_q_in [PQ_W];
   logic [2:0][PQ_W-1:0]      dv_q_src [PQ_W];
   logic [N2_W-1:0]           dv_n2_ff [PQ_W];
   logic [N2_W-1:0]           dv_n2_src [PQ_W];
   side_type                  dv_side_ff [PQ_W];
   side_type                  dv_side_src [PQ_W];
   logic [PROD_W-1:0]         dv_den [PQ_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         pa_valid_ff <= 1'b0;
         pb_valid_ff <= 1'b0;
         dv_valid_ff <= '0;
      end else if (en) begin
         pa_valid_ff <= in_valid;
         pb_valid_ff <= pa_valid_ff;
         dv_valid_ff <= dv_valid_src;
      end
   end

   // 32 x 32 partial products, then recombine
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            pa_lo_ff[i] <= N2_W'(in_data.vabs[i]) * N2_W'(in_data.dmag[HALF-1:0]);
            pa_hi_ff[i] <= N2_W'(in_data.vabs[i]) * N2_W'(in_data.dmag[N2_W-1:HALF]);
            pb_prod_ff[i] <= PROD_W'(pa_lo_ff[i]) + (PROD_W'(pa_hi_ff[i]) << HALF);
         end
         pa_n2_ff   <= in_data.n2;
         pa_side_ff <= in_data.side;
         pb_n2_ff   <= pa_n2_ff;
         pb_side_ff <= pa_side_ff;
      end
   end

   // restoring division, most significant quotient bit first
   always_comb begin
      dv_rem_src[0]   = pb_prod_ff;
      dv_q_src[0]     = '0;
      dv_n2_src[0]    = pb_n2_ff;
      dv_side_src[0]  = pb_side_ff;
      dv_valid_src[0] = pb_valid_ff;
      for (int k = 1; k < PQ_W; k++) begin
         dv_rem_src[k]   = dv_rem_ff[k-1];
         dv_q_src[k]     = dv_q_ff[k-1];
         dv_n2_src[k]    = dv_n2_ff[k-1];
         dv_side_src[k]  = dv_side_ff[k-1];
         dv_valid_src[k] = dv_valid_ff[k-1];
      end
      for (int k = 0; k < PQ_W; k++) begin
         dv_den[k] = PROD_W'(dv_n2_src[k]) << (PQ_W - 1 - k);
         for (int i = 0; i < 3; i++) begin
            if (dv_rem_src[k][i] >= dv_den[k]) begin
               dv_rem_in[k][i] = dv_rem_src[k][i] - dv_den[k];
               dv_q_in[k][i]   = dv_q_src[k][i] | (PQ_W'(1) << (PQ_W - 1 - k));
            end else begin
               dv_rem_in[k][i] = dv_rem_src[k][i];
               dv_q_in[k][i]   = dv_q_src[k][i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < PQ_W; k++) begin
            dv_rem_ff[k]  <= dv_rem_in[k];
            dv_q_ff[k]    <= dv_q_in[k];
            dv_n2_ff[k]   <= dv_n2_src[k];
            dv_side_ff[k] <= dv_side_src[k];
         end
      end
   end

   assign out_valid     = dv_valid_ff[PQ_W-1];
   assign out_data.pm   = dv_q_ff[PQ_W-1];
   assign out_data.side = dv_side_ff[PQ_W-1];

endmodule

`default_nettype wire

[design/lrvs_scale.sv]
// Back end: perpendicular part, scaling by 1/gamma^3 and 1/gamma, sum,
// saturation and the result register. Four stages; depends on lrvs_pkg.
`default_nettype none

module lrvs_scale (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [lrvs_pkg::G_W-1:0]     g,
   input  logic [lrvs_pkg::G_W-1:0]     g3,
   input  lrvs_pkg::par_type            in_data,
   output logic                         out_valid,
   output logic [2:0][lrvs_pkg::D_W-1:0] out_data,
   output logic                         applied
);
   import lrvs_pkg::*;

   localparam int S     = SCALE_FRAC_BITS;
   localparam int PE_W  = D_W + 3;      // signed perpendicular part
   localparam int PM_W  = D_W + 2;      // its magnitude
   localparam int MP_W  = PQ_W + G_W;
   localparam int MQ_W  = PM_W + G_W;
   localparam int Q_W   = PM_W;         // scaled magnitudes
   localparam int SUM_W = Q_W + 2;

   // stage 1
   logic                  s1_valid_ff;
   logic [2:0][PE_W-1:0]  s1_perp_ff;
   logic [2:0][PQ_W-1:0]  s1_pm_ff;
   side_type              s1_side_ff;
   logic [G_W-1:0]        s1_g_ff, s1_g3_ff;

   // stage 2
   logic                  s2_valid_ff;
   logic [2:0][PM_W-1:0]  s2_pmag_ff;
   logic [2:0]            s2_pneg_ff;
   logic [2:0][PQ_W-1:0]  s2_pm_ff;
   side_type              s2_side_ff;
   logic [G_W-1:0]        s2_g_ff, s2_g3_ff;

   // stage 3
   logic                  s3_valid_ff;
   logic [2:0][Q_W-1:0]   s3_mp_ff, s3_mq_ff;
   logic [2:0]            s3_pneg_ff;
   side_type              s3_side_ff;

   // result register
   logic                  s4_valid_ff;
   logic [2:0][D_W-1:0]   s4_data_ff, s4_data_in;
   logic                  s4_applied_ff;
   logic [2:0][SUM_W-1:0] sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // perp = r - par, with par = +/- pm
         for (int i = 0; i < 3; i++) begin
            s1_perp_ff[i] <= in_data.side.psgn[i]
                           ? PE_W'($signed(in_data.side.r[i])) + PE_W'(in_data.pm[i])
                           : PE_W'($signed(in_data.side.r[i])) - PE_W'(in_data.pm[i]);
         end
         s1_pm_ff   <= in_data.pm;
         s1_side_ff <= in_data.side;
         s1_g_ff    <= g;
         s1_g3_ff   <= g3;

         // magnitude of perp
         for (int i = 0; i < 3; i++) begin
            s2_pneg_ff[i] <= s1_perp_ff[i][PE_W-1];
            s2_pmag_ff[i] <= s1_perp_ff[i][PE_W-1] ? PM_W'(PE_W'(0) - s1_perp_ff[i])
                                                   : PM_W'(s1_perp_ff[i]);
         end
         s2_pm_ff   <= s1_pm_ff;
         s2_side_ff <= s1_side_ff;
         s2_g_ff    <= s1_g_ff;
         s2_g3_ff   <= s1_g3_ff;

         // truncated products against 1/gamma^3 and 1/gamma
         for (int i = 0; i < 3; i++) begin
            s3_mp_ff[i] <= Q_W'((MP_W'(s2_pm_ff[i]) * MP_W'(s2_g3_ff)) >> S);
            s3_mq_ff[i] <= Q_W'((MQ_W'(s2_pmag_ff[i]) * MQ_W'(s2_g_ff)) >> S);
         end
         s3_pneg_ff <= s2_pneg_ff;
         s3_side_ff <= s2_side_ff;

         s4_data_ff    <= s4_data_in;
         s4_applied_ff <= !s3_side_ff.bypass;
      end
   end

   // signed sum, saturation to 32 bits, pass-through select
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum[i] = (s3_side_ff.psgn[i] ? SUM_W'(0) - SUM_W'(s3_mp_ff[i]) : SUM_W'(s3_mp_ff[i]))
                + (s3_pneg_ff[i] ? SUM_W'(0) - SUM_W'(s3_mq_ff[i]) : SUM_W'(s3_mq_ff[i]));
         if (s3_side_ff.bypass) begin
            s4_data_in[i] = s3_side_ff.r[i];
         end else if ((sum[i][SUM_W-1:D_W-1] == '0) || (sum[i][SUM_W-1:D_W-1] == '1)) begin
            s4_data_in[i] = sum[i][D_W-1:0];
         end else begin
            s4_data_in[i] = {sum[i][SUM_W-1], {(D_W-1){!sum[i][SUM_W-1]}}};
         end
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_data  = s4_data_ff;
   assign applied   = s4_applied_ff;

endmodule

`default_nettype wire

[test/lrvs_checker.sv]
// Scoreboard for the Lorentz response scaler: predicts each result from the
// accepted request beats and compares rsp beats in order. Uses lrvs_pkg.
`timescale 1ns / 100ps

module lrvs_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [6*lrvs_pkg::D_W-1:0] req_tdata,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [3*lrvs_pkg::D_W-1:0] rsp_tdata,
   input  logic                       rsp_tuser,
   input  logic                       csr_wr_en,
   input  logic [lrvs_pkg::LS_W-1:0]  csr_wr_data,
   output int                         fail_count,
   output int                         pending
);
   import lrvs_pkg::*;

   typedef struct packed {
      logic [2:0][D_W-1:0] comp;
      logic                applied;
   } scaled_type;

   scaled_type       scaled_q[$];
   logic [LS_W-1:0]  light_speed;

   function automatic longint unsigned mag(input longint x);
      return (x < 0) ? longint'(0) - x : x;
   endfunction

   // x * k / 2^S truncated toward zero
   function automatic longint trunc_scale(input longint x, input logic [127:0] k);
      logic [127:0] m;
      m = ((128'(mag(x)) * k) >> SCALE_FRAC_BITS);
      return (x < 0) ? -longint'(m[63:0]) : longint'(m[63:0]);
   endfunction

   function automatic scaled_type lorentz_scale(input logic [LS_W-1:0] ls,
                                               input logic [6*D_W-1:0] d);
      scaled_type       res;
      longint           r [3];
      longint           v [3];
      longint           p, par, perp, sum;
      longint unsigned  n2, c2, pos, neg, dmag;
      logic [127:0]     om, g, g3, cand, q, pm;
      logic             dneg;
      n2 = 0;
      for (int i = 0; i < 3; i++) begin
         r[i] = longint'($signed(d[D_W*i +: D_W]));
         v[i] = longint'($signed(d[D_W*(3+i) +: D_W]));
         n2 += mag(v[i]) * mag(v[i]);
         res.comp[i] = d[D_W*i +: D_W];
      end
      res.applied = 1'b0;
      c2 = longint'(ls) * longint'(ls);
      if (ls < MIN_LIGHT_RAW || n2 == 0 || (r[0] == 0 && r[1] == 0 && r[2] == 0) ||
          n2 <= (c2 >> TINY_SHIFT))
         return res;
      // 1 - beta^2, floored at one LSB
      if (n2 >= c2) begin
         om = 1;
      end else begin
         q  = (128'(n2) << SCALE_FRAC_BITS) / 128'(c2);
         om = (128'(1) << SCALE_FRAC_BITS) - q;
      end
      // 1/gamma by bitwise square root
      g = 0;
      for (int i = SCALE_FRAC_BITS; i >= 0; i--) begin
         cand = g | (128'(1) << i);
         if (cand * cand <= (om << SCALE_FRAC_BITS))
            g = cand;
      end
      g3 = (((g * g) >> SCALE_FRAC_BITS) * g) >> SCALE_FRAC_BITS;
      // r.v as sign and magnitude
      pos = 0;
      neg = 0;
      for (int i = 0; i < 3; i++) begin
         p = r[i] * v[i];
         if (p < 0) neg += mag(p);
         else       pos += p;
      end
      dneg = neg > pos;
      dmag = dneg ? neg - pos : pos - neg;
      for (int i = 0; i < 3; i++) begin
         pm   = (128'(mag(v[i])) * 128'(dmag)) / 128'(n2);
         par  = ((v[i] < 0) != dneg) ? -longint'(pm[63:0]) : longint'(pm[63:0]);
         perp = r[i] - par;
         sum  = trunc_scale(par, g3) + trunc_scale(perp, g);
         if (sum > 64'sd2147483647)       sum = 64'sd2147483647;
         else if (sum < -64'sd2147483648) sum = -64'sd2147483648;
         res.comp[i] = sum[D_W-1:0];
      end
      res.applied = 1'b1;
      return res;
   endfunction

   // track register, predict on request beats, compare on result beats
   always @(posedge clock) begin
      scaled_type exp_res;
      int         errs;
      errs = 0;
      if (reset) begin
         light_speed <= LS_RESET;
         fail_count  <= 0;
         pending     <= 0;
      end else begin
         if (csr_wr_en)
            light_speed <= csr_wr_data;
         if (req_tvalid && req_tready)
            scaled_q.push_back(lorentz_scale(light_speed, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (scaled_q.size() == 0) begin
               $error("result beat with nothing expected");
               errs++;
            end else begin
               exp_res = scaled_q.pop_front();
               for (int i = 0; i < 3; i++)
                  if (rsp_tdata[D_W*i +: D_W] !== exp_res.comp[i]) begin
                     $error("out_%s expected %h actual %h",
                            (i == 0) ? "x" : (i == 1) ? "y" : "z",
                            exp_res.comp[i], rsp_tdata[D_W*i +: D_W]);
                     errs++;
                  end
               if (rsp_tuser !== exp_res.applied) begin
                  $error("applied expected %b actual %b", exp_res.applied, rsp_tuser);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending    <= scaled_q.size();
      end
   end

endmodule

[test/testbench.sv]
// Stimulus and verdict for the Lorentz response scaler; depends on lrvs_pkg,
// lorentz_response_vector_scale_top and the lrvs_checker scoreboard.
`timescale 1ns / 100ps

module testbench;
   import lrvs_pkg::*;

   localparam int WATCHDOG = 5000;
   localparam int DRAIN    = 80;
   localparam int LONG_HOLD = 300;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [6*D_W-1:0]    req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [3*D_W-1:0]    rsp_tdata;
   logic                rsp_tuser;
   logic                csr_wr_en = 1'b0;
   logic [LS_W-1:0]     csr_wr_data = '0;
   int                  fail_count, pending;

   int                  send_idle_pct = 0;
   int                  recv_stall_pct = 0;
   int                  hold_asked = 0;
   int                  hold_done = 0;
   int                  hold_left = 0;
   int                  quiet_cycles = 0;
   logic [LS_W-1:0]     cur_ls = LS_RESET;

   always #6 clock = ~clock;

   lorentz_response_vector_scale_top DUT (.*);

   lrvs_checker u_checker (.*);

   // receiver: random stalls plus an occasional long hold-off
   always @(posedge clock) begin
      if (hold_asked != hold_done) begin
         hold_done  <= hold_asked;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   task automatic send_beat(input logic [2:0][D_W-1:0] r, input logic [2:0][D_W-1:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {v, r};
      do @(posedge clock); while (!req_tready);
   endtask

   // register writes only with the pipeline empty
   task automatic write_light_speed(input logic [LS_W-1:0] ls);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ls;
      cur_ls      = ls;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [D_W-1:0] rand_speed(input logic [LS_W-1:0] ls);
      logic [D_W-1:0] m;
      case ($urandom_range(9))
         0:       return $urandom;
         1:       return '0;
         default: begin
            m = $urandom_range(ls, 0) >> $urandom_range(3);
            return $urandom_range(1) ? -m : m;
         end
      endcase
   endfunction

   function automatic logic [D_W-1:0] rand_resp();
      case ($urandom_range(9))
         0:       return '0;
         1, 2:    return $signed($urandom_range(20'hFFFFF)) - 32'sd524288;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_phase(input int items, input int idle, input int stall,
                               input bit hold);
      logic [2:0][D_W-1:0] r, v;
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      for (int n = 0; n < items; n++) begin
         if (hold && n == 10) hold_asked++;
         for (int i = 0; i < 3; i++) begin
            r[i] = rand_resp();
            v[i] = rand_speed(cur_ls);
         end
         if ($urandom_range(19) == 0) r = '0;
         send_beat(r, v);
      end
   endtask

   localparam logic [D_W-1:0] MAXP = 32'h7FFFFFFF;
   localparam logic [D_W-1:0] MAXN = 32'h80000000;
   localparam logic [D_W-1:0] ONE  = 32'h00010000;

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_light_speed(LS_RESET);
      // directed: extremes and each pass-through case
      send_beat({MAXP, MAXP, MAXP}, {MAXP, MAXP, MAXP});
      send_beat({MAXN, MAXN, MAXN}, {MAXN, MAXN, MAXN});
      send_beat({MAXP, MAXN, MAXP}, {MAXN, MAXP, MAXN});
      send_beat({ONE, ONE, ONE}, '0);
      send_beat('0, {ONE, ONE, ONE});
      send_beat({ONE, -ONE, ONE}, {32'd0, 32'd0, 32'd7240});
      send_beat({ONE, -ONE, ONE}, {32'd0, 32'd0, 32'd7241});
      send_beat({ONE, -ONE, ONE}, {32'd0, 32'd0, 32'd5242880});
      send_beat({ONE, -ONE, ONE}, {32'd0, 32'd5242879, 32'd0});
      send_beat({ONE, 32'd0, 32'd0}, {-32'sd2621440, 32'd0, 32'd0});
      send_beat({MAXP, 32'd0, MAXN}, {32'd5000000, 32'd1000000, -32'sd1000000});
      send_beat({MAXP, MAXP, MAXP}, {32'd3000000, 32'd3000000, 32'd3000000});
      write_light_speed(LS_W'(65));
      send_beat({ONE, ONE, ONE}, {ONE, ONE, ONE});
      write_light_speed(LS_W'(66));
      send_beat({ONE, ONE, ONE}, {32'd30, 32'd20, 32'd10});
      send_beat({ONE, ONE, ONE}, {32'd0, 32'd0, 32'd0});
      send_beat({MAXP, MAXN, ONE}, {MAXN, MAXN, MAXN});
      write_light_speed(LS_W'(0));
      send_beat({ONE, ONE, ONE}, {ONE, ONE, ONE});
      write_light_speed(31'h7FFFFFFF);
      send_beat({MAXP, MAXN, MAXP}, {MAXN, MAXN, MAXN});
      send_beat({MAXN, MAXP, ONE}, {MAXP, 32'd0, 32'd0});
      // random phases over several light speeds and idle mixes
      random_phase(120, 0, 0, 1'b0);
      write_light_speed(LS_RESET);
      random_phase(150, 0, 0, 1'b1);
      random_phase(100, 75, 0, 1'b0);
      write_light_speed(LS_W'(1000));
      random_phase(100, 0, 75, 1'b0);
      write_light_speed(LS_W'(66));
      random_phase(80, 14, 14, 1'b0);
      write_light_speed(LS_W'($urandom));
      random_phase(100, 14, 14, 1'b1);
      write_light_speed(LS_RESET);
      random_phase(100, 0, 0, 1'b0);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (fail_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

[filelist.f]
design/lrvs_pkg.sv
design/lrvs_prep.sv
design/lrvs_gamma.sv
design/lrvs_par_div.sv
design/lrvs_scale.sv
design/lorentz_response_vector_scale_top.sv
test/lrvs_checker.sv
test/testbench.sv
